// ===== design/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg: shared types, constants and functions
// Header positions, the result word layout and the ones' complement adder
// used by the checksum stream core.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;
  localparam int unsigned LenW  = 32;

  localparam logic [ByteW-1:0] UpperA  = 8'h41;
  localparam logic [ByteW-1:0] UpperZ  = 8'h5A;
  localparam logic [ByteW-1:0] LowerA  = 8'h61;
  localparam logic [ByteW-1:0] LowerZ  = 8'h7A;
  localparam logic [ByteW-1:0] CaseBit = 8'h20;
  localparam logic [5:0]       Alpha   = 6'd26;
  localparam logic [SumW-1:0]  WordMax = 16'hFFFF;

  // Position in the packet: header bytes 0..7, then the message body.
  typedef logic [3:0] hdr_idx_t;
  localparam hdr_idx_t HDR_MODE    = 4'd0;
  localparam hdr_idx_t HDR_SHIFT   = 4'd1;
  localparam hdr_idx_t HDR_CSUM_LO = 4'd2;
  localparam hdr_idx_t HDR_CSUM_HI = 4'd3;
  localparam hdr_idx_t HDR_LEN_0   = 4'd4;
  localparam hdr_idx_t HDR_LEN_1   = 4'd5;
  localparam hdr_idx_t HDR_LEN_2   = 4'd6;
  localparam hdr_idx_t HDR_LEN_3   = 4'd7;
  localparam hdr_idx_t HDR_BODY    = 4'd8;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             has_byte;
    logic             is_last;
    logic             checksum_ok;
    logic [SumW-1:0]  reply_checksum;
    logic             reply_mode;
  } ccs_result_t;

  // Ones' complement add with end-around carry.
  function automatic logic [SumW-1:0] oc_add(input logic [SumW-1:0] a,
                                             input logic [SumW-1:0] b);
    logic [SumW:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SumW-1:0] + {{(SumW-1){1'b0}}, t[SumW]};
  endfunction

  // Shift amount reduced mod 26 by restoring subtraction of 208, 104, 52, 26.
  function automatic logic [4:0] mod26(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = v;
    if (r >= 8'd208) r = r - 8'd208;
    if (r >= 8'd104) r = r - 8'd104;
    if (r >= 8'd52)  r = r - 8'd52;
    if (r >= 8'd26)  r = r - 8'd26;
    return r[4:0];
  endfunction

endpackage

// ===== design/caesar_checksum_stream_core.sv =====
// ----------------------------------------------------------------------------
// caesar_checksum_stream_core: byte stream cipher with checksums
// Parses an 8-byte header, rotates message letters and keeps the received
// and reply ones' complement sums; the last result carries the status.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  -----------------------------------------
//   input    in_valid / in_stall  in_byte
//   output   out_valid/out_stall  out_byte, has_byte, is_last, checksum_ok,
//                                 reply_checksum, reply_mode
//
// One word is accepted per cycle while in_stall is low. A word's result is
// registered in the result register, or in the skid entry behind it when the
// output is stalled; the per-cycle limit is one end-around-carry add on each
// of the two sums, done between the state registers and the result register.
// Header words give no result, except the last header word of an empty message, which carries the status.
// Reset is synchronous and active high; it returns the parser to the first
// header byte and empties the output buffer.
// in_stall rises only when both the result register and its skid entry are
// full, so a stalled output costs no input cycle until two results wait.
//
module caesar_checksum_stream_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ccs_pkg::ByteW-1:0] in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ccs_pkg::ByteW-1:0] out_byte,
  output logic                      has_byte,
  output logic                      is_last,
  output logic                      checksum_ok,
  output logic [ccs_pkg::SumW-1:0]  reply_checksum,
  output logic                      reply_mode
);
  import ccs_pkg::*;

  logic        accept;
  logic        res_valid;
  ccs_result_t res;
  ccs_result_t out_data;
  logic        buf_full;

  // A word is taken whenever the skid entry is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  ccs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ccs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign out_byte       = out_data.out_byte;
  assign has_byte       = out_data.has_byte;
  assign is_last        = out_data.is_last;
  assign checksum_ok    = out_data.checksum_ok;
  assign reply_checksum = out_data.reply_checksum;
  assign reply_mode     = out_data.reply_mode;

  // The skid entry is only ever filled behind an occupied result register.
  a_skid_behind_main : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry full while result register empty");

  // A result that does not close a packet always carries a message byte.
  a_mid_has_byte : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> has_byte)
    else $error("non-final result without a message byte");

  // Status fields stay clear on results that do not close a packet.
  a_mid_status_clear : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_last) |-> (!checksum_ok && !reply_mode && reply_checksum == '0))
    else $error("status fields set on a non-final result");

  // Nothing is presented in the first cycle out of reset.
  a_reset_empty : assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!out_valid && !in_stall))
    else $error("output buffer not empty after reset");

endmodule

// ===== design/ccs_cipher.sv =====
// ----------------------------------------------------------------------------
// ccs_cipher: byte transform
// Lowercases A..Z, then rotates a..z forward or backward by the shift.
// ----------------------------------------------------------------------------
module ccs_cipher (
  input  logic [ccs_pkg::ByteW-1:0] plain,
  input  logic [4:0]                shift_mod,
  input  logic                      mode_nz,
  output logic [ccs_pkg::ByteW-1:0] cipher
);
  import ccs_pkg::*;

  logic [ByteW-1:0] lower;
  logic [5:0]       addend;
  logic [5:0]       rot;

  always_comb begin
    lower = plain;
    if (plain >= UpperA && plain <= UpperZ) begin
      lower = plain + CaseBit;
    end
    // Backward rotation adds 26 - s so that the sum stays below 52.
    addend = mode_nz ? (Alpha - {1'b0, shift_mod}) : {1'b0, shift_mod};
    rot    = {1'b0, lower[4:0] - LowerA[4:0]} + addend;
    if (rot >= Alpha) begin
      rot = rot - Alpha;
    end
    cipher = lower;
    if (lower >= LowerA && lower <= LowerZ) begin
      cipher = LowerA + {2'b00, rot};
    end
  end

endmodule

// ===== design/ccs_core.sv =====
// ----------------------------------------------------------------------------
// ccs_core: packet parser and checksum state
// Tracks the header position and both running sums, and forms the result for
// each message byte and for the last header byte of an empty message.
// ----------------------------------------------------------------------------
module ccs_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [ccs_pkg::ByteW-1:0] in_byte,
  output logic                      res_valid,
  output ccs_pkg::ccs_result_t      res
);
  import ccs_pkg::*;

  hdr_idx_t         hdr_idx, hdr_idx_next;
  logic             mode_nz, mode_nz_next;
  logic [4:0]       shift_mod, shift_mod_next;
  logic [23:0]      len_hi, len_hi_next;
  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic [SumW-1:0]  rx_sum, rx_sum_next;
  logic [SumW-1:0]  tx_sum, tx_sum_next;
  logic [ByteW-1:0] held_in, held_in_next;
  logic [ByteW-1:0] held_out, held_out_next;
  logic             byte_held, byte_held_next;

  logic [ByteW-1:0] cipher;
  logic [LenW-1:0]  full_len;
  logic             body_last;

  ccs_cipher u_cipher (
    .plain     (in_byte),
    .shift_mod (shift_mod),
    .mode_nz   (mode_nz),
    .cipher    (cipher)
  );

  assign full_len  = {len_hi, in_byte};
  assign body_last = (bytes_left[LenW-1:1] == '0);

  always_comb begin
    hdr_idx_next    = hdr_idx;
    mode_nz_next    = mode_nz;
    shift_mod_next  = shift_mod;
    len_hi_next     = len_hi;
    bytes_left_next = bytes_left;
    rx_sum_next     = rx_sum;
    tx_sum_next     = tx_sum;
    held_in_next    = held_in;
    held_out_next   = held_out;
    byte_held_next  = byte_held;
    res_valid       = 1'b0;
    res             = '0;
    if (accept) begin
      case (hdr_idx)
        HDR_MODE: begin
          rx_sum_next    = '0;
          tx_sum_next    = '0;
          byte_held_next = 1'b0;
          mode_nz_next   = |in_byte;
          held_in_next   = in_byte;
          hdr_idx_next   = HDR_SHIFT;
        end
        HDR_SHIFT: begin
          shift_mod_next = mod26(in_byte);
          rx_sum_next    = oc_add(rx_sum, {in_byte, held_in});
          tx_sum_next    = oc_add(tx_sum, {in_byte, 7'b0, mode_nz});
          hdr_idx_next   = HDR_CSUM_LO;
        end
        HDR_CSUM_LO: begin
          held_in_next = in_byte;
          hdr_idx_next = HDR_CSUM_HI;
        end
        HDR_CSUM_HI: begin
          rx_sum_next  = oc_add(rx_sum, {in_byte, held_in});
          hdr_idx_next = HDR_LEN_0;
        end
        HDR_LEN_0, HDR_LEN_2: begin
          held_in_next = in_byte;
          len_hi_next  = {len_hi[15:0], in_byte};
          hdr_idx_next = hdr_idx + 4'd1;
        end
        HDR_LEN_1: begin
          rx_sum_next  = oc_add(rx_sum, {in_byte, held_in});
          tx_sum_next  = oc_add(tx_sum, {in_byte, held_in});
          len_hi_next  = {len_hi[15:0], in_byte};
          hdr_idx_next = HDR_LEN_2;
        end
        HDR_LEN_3: begin
          rx_sum_next     = oc_add(rx_sum, {in_byte, held_in});
          tx_sum_next     = oc_add(tx_sum, {in_byte, held_in});
          bytes_left_next = full_len;
          byte_held_next  = 1'b0;
          if (full_len == '0) begin
            // Empty message: the status goes out with the header's last byte.
            res_valid          = 1'b1;
            res.is_last        = 1'b1;
            res.checksum_ok    = (rx_sum_next == WordMax);
            res.reply_checksum = ~tx_sum_next;
            res.reply_mode     = mode_nz;
            hdr_idx_next       = HDR_MODE;
          end else begin
            hdr_idx_next = HDR_BODY;
          end
        end
        HDR_BODY: begin
          if (byte_held) begin
            rx_sum_next    = oc_add(rx_sum, {in_byte, held_in});
            tx_sum_next    = oc_add(tx_sum, {cipher, held_out});
            byte_held_next = 1'b0;
          end else if (body_last) begin
            // Odd final byte is padded as the low byte of a word.
            rx_sum_next = oc_add(rx_sum, {8'h00, in_byte});
            tx_sum_next = oc_add(tx_sum, {8'h00, cipher});
          end else begin
            held_in_next   = in_byte;
            held_out_next  = cipher;
            byte_held_next = 1'b1;
          end
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - LenW'(1);
          end
          res_valid    = 1'b1;
          res.out_byte = cipher;
          res.has_byte = 1'b1;
          if (body_last) begin
            res.is_last        = 1'b1;
            res.checksum_ok    = (rx_sum_next == WordMax);
            res.reply_checksum = ~tx_sum_next;
            res.reply_mode     = mode_nz;
            hdr_idx_next       = HDR_MODE;
          end
        end
        default: begin
          hdr_idx_next = HDR_MODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx   <= HDR_MODE;
      byte_held <= 1'b0;
    end else begin
      hdr_idx   <= hdr_idx_next;
      byte_held <= byte_held_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_nz    <= mode_nz_next;
    shift_mod  <= shift_mod_next;
    len_hi     <= len_hi_next;
    bytes_left <= bytes_left_next;
    rx_sum     <= rx_sum_next;
    tx_sum     <= tx_sum_next;
    held_in    <= held_in_next;
    held_out   <= held_out_next;
  end

endmodule

// ===== design/ccs_out_buf.sv =====
// ----------------------------------------------------------------------------
// ccs_out_buf: result register with skid entry
// Holds the presented result and one more, so input need not wait on a
// stalled output.
// ----------------------------------------------------------------------------
module ccs_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ccs_pkg::ccs_result_t push_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ccs_pkg::ccs_result_t out_data,
  output logic                 full
);
  import ccs_pkg::*;

  logic        main_valid, main_valid_next;
  logic        skid_valid, skid_valid_next;
  ccs_result_t main_data, main_data_next;
  ccs_result_t skid_data, skid_data_next;
  logic        pop;

  assign pop = main_valid && !out_stall;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_data_next  = main_data;
    skid_data_next  = skid_data;
    if (skid_valid) begin
      // Input is held off while the skid entry is occupied.
      if (pop) begin
        main_data_next  = skid_data;
        skid_valid_next = 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_data_next  = push_data;
        main_valid_next = 1'b1;
      end else begin
        skid_data_next  = push_data;
        skid_valid_next = 1'b1;
      end
    end else if (pop) begin
      main_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main_data <= main_data_next;
    skid_data <= skid_data_next;
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

endmodule

// ===== test/ccs_result_checker.sv =====
// ----------------------------------------------------------------------------
// ccs_result_checker: result predictor and comparator for the cipher core
// Watches both channels, keeps its own copy of the parser, cipher and
// checksum state, and compares each accepted result word with the oldest
// expected one.
// ----------------------------------------------------------------------------
module ccs_result_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ccs_pkg::ByteW-1:0] in_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ccs_pkg::ByteW-1:0] out_byte,
  input  logic                      has_byte,
  input  logic                      is_last,
  input  logic                      checksum_ok,
  input  logic [ccs_pkg::SumW-1:0]  reply_checksum,
  input  logic                      reply_mode,
  output int                        mismatches,
  output int                        awaiting
);
  import ccs_pkg::*;

  localparam int AlphaN    = Alpha;

  hdr_idx_t         hdr_pos;
  logic [ByteW-1:0] mode_q;
  logic [ByteW-1:0] shift_q;
  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  remaining_q;
  logic [SumW-1:0]  rx_sum;
  logic [SumW-1:0]  tx_sum;
  logic [ByteW-1:0] low_in;
  logic [ByteW-1:0] low_out;
  logic             half_word;

  ccs_result_t expected_results[$];
  int          results_seen;

  function automatic logic [SumW-1:0] ones_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[SumW-1:0] + {{(SumW-1){1'b0}}, wide[SumW]};
  endfunction

  function automatic logic [ByteW-1:0] rotate_letter(input logic [ByteW-1:0] b);
    int               k;
    int               p;
    logic [ByteW-1:0] c;
    k = int'(shift_q);
    k = k % AlphaN;
    c = b;
    if (c >= UpperA && c <= UpperZ) c = c + CaseBit;
    if (c >= LowerA && c <= LowerZ) begin
      p = int'(c - LowerA);
      if (mode_q == 0) p = (p + k) % AlphaN;
      else p = (p + AlphaN - k) % AlphaN;
      c = LowerA + p[ByteW-1:0];
    end
    return c;
  endfunction

  // Status fields are only meaningful on the last word of a packet.
  task automatic push_result(input logic [ByteW-1:0] c, input logic has,
                             input logic last);
    ccs_result_t r;
    r.out_byte       = c;
    r.has_byte       = has;
    r.is_last        = last;
    r.checksum_ok    = last && (rx_sum == WordMax);
    r.reply_checksum = last ? ~tx_sum : '0;
    r.reply_mode     = last && (mode_q != 0);
    expected_results.push_back(r);
  endtask

  task automatic cipher_and_sum(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    if (hdr_pos < HDR_BODY) begin
      if (hdr_pos == HDR_MODE) begin
        rx_sum    = '0;
        tx_sum    = '0;
        half_word = 1'b0;
        mode_q    = b;
      end else if (hdr_pos == HDR_SHIFT) begin
        shift_q = b;
      end else if (hdr_pos >= HDR_LEN_0) begin
        len_q = {len_q[LenW-9:0], b};
      end
      if (!hdr_pos[0]) low_in = b;
      else rx_sum = ones_add(rx_sum, {b, low_in});
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos == HDR_BODY) begin
        // Reply header: mode flag, shift, zero checksum, length big-endian.
        tx_sum = ones_add('0, {shift_q, 7'b0, mode_q != 0});
        tx_sum = ones_add(tx_sum, {len_q[23:16], len_q[31:24]});
        tx_sum = ones_add(tx_sum, {len_q[7:0], len_q[15:8]});
        remaining_q = len_q;
        half_word   = 1'b0;
        if (len_q == 0) begin
          push_result('0, 1'b0, 1'b1);
          hdr_pos = HDR_MODE;
        end
      end
    end else begin
      c = rotate_letter(b);
      if (!half_word) begin
        low_in    = b;
        low_out   = c;
        half_word = 1'b1;
      end else begin
        rx_sum    = ones_add(rx_sum, {b, low_in});
        tx_sum    = ones_add(tx_sum, {c, low_out});
        half_word = 1'b0;
      end
      if (remaining_q != 0) remaining_q = remaining_q - LenW'(1);
      if (remaining_q == 0) begin
        // An odd final byte goes in as the low half of a word.
        if (half_word) begin
          rx_sum    = ones_add(rx_sum, {8'h00, low_in});
          tx_sum    = ones_add(tx_sum, {8'h00, low_out});
          half_word = 1'b0;
        end
        push_result(c, 1'b1, 1'b1);
        hdr_pos = HDR_MODE;
      end else begin
        push_result(c, 1'b1, 1'b0);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    ccs_result_t want;
    if (rst) begin
      hdr_pos      = HDR_MODE;
      mode_q       = '0;
      shift_q      = '0;
      len_q        = '0;
      remaining_q  = '0;
      rx_sum       = '0;
      tx_sum       = '0;
      low_in       = '0;
      low_out      = '0;
      half_word    = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      expected_results.delete();
      awaiting     = 0;
    end else begin
      // The output side goes first: a result seen at this edge belongs to a
      // word accepted at an earlier edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing expected", out_byte, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch("out_byte", out_byte, want.out_byte);
          if (has_byte !== want.has_byte)
            report_mismatch("has_byte", has_byte, want.has_byte);
          if (is_last !== want.is_last)
            report_mismatch("is_last", is_last, want.is_last);
          if (checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", checksum_ok, want.checksum_ok);
          if (reply_checksum !== want.reply_checksum)
            report_mismatch("reply_checksum", reply_checksum, want.reply_checksum);
          if (reply_mode !== want.reply_mode)
            report_mismatch("reply_mode", reply_mode, want.reply_mode);
        end
        results_seen = results_seen + 1;
      end
      if (in_valid && !in_stall) cipher_and_sum(in_byte);
      awaiting = expected_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for caesar_checksum_stream_core
// Sends directed and random packets through the core under several sender
// idle and receiver stall mixes; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ccs_pkg::*;

  // Generous bound: far beyond the slowest correct run at full stall rates.
  localparam int RunLimit   = 2400000;
  localparam int WordTarget = 490;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    in_byte   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ByteW-1:0]    out_byte;
  logic                has_byte;
  logic                is_last;
  logic                checksum_ok;
  logic [SumW-1:0]     reply_checksum;
  logic                reply_mode;

  int mismatches;
  int awaiting;

  // Percent chances of a sender gap and of a receiver stall in a cycle.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Cycles the receiver still has to hold off for a forced backpressure run.
  int hold_left     = 0;
  int words_sent    = 0;
  int phase         = 0;

  logic [ByteW-1:0] body[$];
  logic [ByteW-1:0] packet[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  caesar_checksum_stream_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .is_last        (is_last),
    .checksum_ok    (checksum_ok),
    .reply_checksum (reply_checksum),
    .reply_mode     (reply_mode)
  );

  ccs_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .is_last        (is_last),
    .checksum_ok    (checksum_ok),
    .reply_checksum (reply_checksum),
    .reply_mode     (reply_mode),
    .mismatches     (mismatches),
    .awaiting       (awaiting)
  );

  // Receiver: a forced hold-off takes priority over the random stall mix.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // The sum used to build a valid checksum field for the request header.
  function automatic logic [SumW-1:0] ones_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[SumW-1:0] + {{(SumW-1){1'b0}}, wide[SumW]};
  endfunction

  // Message bytes lean on letters of both cases and on the bytes just
  // outside the letter ranges, with fully random bytes mixed in.
  function automatic logic [ByteW-1:0] text_byte();
    case ($urandom_range(3))
      0: return UpperA + ByteW'($urandom_range(25));
      1: return LowerA + ByteW'($urandom_range(25));
      2: return ByteW'($urandom_range(255));
      default: begin
        case ($urandom_range(7))
          0: return 8'h40;
          1: return 8'h5B;
          2: return 8'h60;
          3: return 8'h7B;
          4: return 8'h80;
          5: return 8'hFF;
          6: return 8'h00;
          default: return 8'h7F;
        endcase
      end
    endcase
  endfunction

  task automatic fill_body(input int n);
    body.delete();
    repeat (n) body.push_back(text_byte());
  endtask

  // One word on the input channel. Valid stays high from one word to the
  // next unless a random gap is taken, and the payload holds while stalled.
  task automatic send_word(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent = words_sent + 1;
  endtask

  // Builds the 8-byte header in front of the current body and sends it all.
  // With fix_sum set the checksum field makes the received sum fold to all
  // ones; otherwise the given value is placed as it is.
  task automatic transmit_packet(input logic [ByteW-1:0] mode,
                                 input logic [ByteW-1:0] shift,
                                 input logic [LenW-1:0] len, input bit fix_sum,
                                 input logic [SumW-1:0] given_sum);
    logic [SumW-1:0] s;
    int              i;
    s = ones_add('0, {shift, mode});
    s = ones_add(s, {len[23:16], len[31:24]});
    s = ones_add(s, {len[7:0], len[15:8]});
    for (i = 0; i + 1 < body.size(); i += 2) s = ones_add(s, {body[i+1], body[i]});
    if (body.size() % 2 == 1) s = ones_add(s, {8'h00, body[body.size()-1]});
    if (fix_sum) given_sum = ~s;
    packet.delete();
    packet.push_back(mode);
    packet.push_back(shift);
    packet.push_back(given_sum[7:0]);
    packet.push_back(given_sum[15:8]);
    packet.push_back(len[31:24]);
    packet.push_back(len[23:16]);
    packet.push_back(len[15:8]);
    packet.push_back(len[7:0]);
    foreach (body[j]) packet.push_back(body[j]);
    foreach (packet[j]) send_word(packet[j]);
  endtask

  // Mostly short messages with a correct checksum; a few longer ones and a
  // few with a random checksum field so the check also fails.
  task automatic random_packet();
    logic [ByteW-1:0] mode;
    int               pick;
    int               n;
    if ($urandom_range(1) == 0) mode = 8'h00;
    else if ($urandom_range(3) == 0) mode = 8'hFF;
    else mode = ByteW'($urandom_range(1, 255));
    pick = $urandom_range(9);
    if (pick == 0) n = 0;
    else if (pick < 8) n = $urandom_range(1, 8);
    else n = $urandom_range(9, 40);
    fill_body(n);
    transmit_packet(mode, ByteW'($urandom_range(255)), LenW'(n),
                    $urandom_range(9) != 0, SumW'($urandom_range(65535)));
  endtask

  // Stop sending and wait for every expected word to arrive. The first
  // edge lets the checker account for the last accepted word.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // All-zero packet: empty message, and the received sum stays zero so
    // the check must fail.
    body.delete();
    transmit_packet(8'h00, 8'h00, 0, 1'b0, 16'h0000);

    // Forward rotation by shift 255, which reduces to 21; a case fold, a wrap
    // past 'z' and a high byte that must pass untouched, with an odd final byte.
    body.delete();
    body.push_back(UpperZ);
    body.push_back(LowerA);
    body.push_back(8'hFF);
    transmit_packet(8'h00, 8'hFF, 3, 1'b1, 16'h0000);

    // Backward rotation with a shift of exactly one alphabet and a bad
    // checksum field.
    body.delete();
    body.push_back(UpperA);
    transmit_packet(8'hFF, 8'd26, 1, 1'b0, 16'hFFFF);

    drain_results();

    // Random traffic, rotating through the idle and stall mixes.
    while (words_sent < WordTarget) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      if (phase == 2) begin
        // Long receiver hold-off while the sender keeps pushing a long
        // message, so the output buffer fills and the input stalls.
        hold_left = 120;
        fill_body(48);
        transmit_packet(8'h00, ByteW'($urandom_range(255)), 48, 1'b1, 16'h0000);
      end
      if (phase == 5) drain_results();
      repeat (5) random_packet();
      phase = phase + 1;
    end

    // A length with its top bit set: only part of the message is sent, so
    // no word may be marked last.
    fill_body(20);
    transmit_packet(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                    32'h8000_0000 | $urandom, 1'b1, 16'h0000);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("caesar_checksum_stream_core verification clean");
    else $display("caesar_checksum_stream_core verification failed");
    $finish;
  end

  initial begin
    #RunLimit;
    $display("caesar_checksum_stream_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ccs_pkg.sv
design/ccs_cipher.sv
design/ccs_core.sv
design/ccs_out_buf.sv
design/caesar_checksum_stream_core.sv
test/ccs_result_checker.sv
test/testbench.sv
